[rtl/murl_pkg.sv]
// shared types, constants and helper functions for the meter uart register link
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package murl_pkg;

    // frame constants
    localparam logic [7:0] HDR_BYTE  = 8'h7D;
    localparam logic [7:0] SUM_BIAS  = 8'h33;
    localparam logic [4:0] MAX_WORDS = 5'd16;

    // job queue between front and back
    localparam int JOB_DEPTH = 4;
    localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
    localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

    // input opcodes
    localparam logic [2:0] OP_WRITE = 3'd0;
    localparam logic [2:0] OP_READ  = 3'd1;
    localparam logic [2:0] OP_BLOCK = 3'd2;
    localparam logic [2:0] OP_RX    = 3'd3;
    localparam logic [2:0] OP_TICK  = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_TX   = 2'd0;
    localparam logic [1:0] KIND_WORD = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_DEVICE     = 3'd0;
    localparam logic [2:0] CFG_READ_OP    = 3'd1;
    localparam logic [2:0] CFG_WRITE_OP   = 3'd2;
    localparam logic [2:0] CFG_BLOCK_OP   = 3'd3;
    localparam logic [2:0] CFG_WRITE_WAIT = 3'd4;
    localparam logic [2:0] CFG_READ_WAIT  = 3'd5;
    localparam logic [2:0] CFG_BLOCK_WAIT = 3'd6;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [6:0]  reg_address;
        logic [31:0] write_data;
        logic [4:0]  word_count;
        logic [7:0]  rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  tx_byte;
        logic [31:0] read_word;
        logic [3:0]  word_index;
        logic        checksum_ok;
        logic        timed_out;
        logic        last;
    } result_t;

    // one unit of work for the back end: a whole request frame or one single result
    typedef struct packed {
        logic        is_frame;
        logic        long_frame;   // write frame with data bytes
        logic [7:0]  cmd1;
        logic [7:0]  cmd2;
        logic [7:0]  cksum;
        logic [31:0] data;         // write data or received word
        logic [1:0]  kind;
        logic [3:0]  index;
        logic        ok;
        logic        to;
    } job_t;

    function automatic logic [7:0] finish_sum(input logic [7:0] s);
        return SUM_BIAS + ~s;
    endfunction

endpackage

`default_nettype wire

[rtl/murl_front.sv]
// front end: configuration registers, protocol state and classification of items
// depends on murl_pkg; emits one job per item that causes results
`timescale 1ns / 1ps
`default_nettype none

module murl_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              take,
    input  wire murl_pkg::in_item_t item,
    input  wire logic              cfg_write,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [7:0]        cfg_data,
    output logic                   job_push,
    output murl_pkg::job_t         job
);
    import murl_pkg::*;

    typedef enum logic [1:0] {PH_IDLE, PH_WRITE, PH_READ, PH_BLOCK} phase_t;

    localparam logic [2:0] SLOT_MARKER = 3'd0;
    localparam logic [2:0] SLOT_FIRST  = 3'd1;
    localparam logic [2:0] SLOT_LAST   = 3'd4;
    localparam logic [2:0] SLOT_SUM    = 3'd5;

    logic [1:0]  device_reg, read_op_reg, write_op_reg, block_op_reg;
    logic [7:0]  write_wait_reg, read_wait_reg, block_wait_reg;

    phase_t      phase_reg, phase_next;
    logic [7:0]  expected_sum_reg, expected_sum_next;
    logic [7:0]  running_sum_reg, running_sum_next;
    logic [2:0]  byte_slot_reg, byte_slot_next;
    logic [4:0]  word_counter_reg, word_counter_next;
    logic [4:0]  words_wanted_reg, words_wanted_next;
    logic [31:0] word_buffer_reg, word_buffer_next;
    logic [7:0]  wait_counter_reg, wait_counter_next;
    logic        job_push_next;
    job_t        job_next;

    logic [7:0]  cmd1_w, sum_w, cmd1_r, cmd2_r, rx_sum;
    logic [4:0]  cnt, cnt_m1, counter_inc;
    logic [1:0]  lane;
    logic [31:0] merged;
    logic [7:0]  wait_inc, limit;

    always_comb
    begin
        phase_next        = phase_reg;
        expected_sum_next = expected_sum_reg;
        running_sum_next  = running_sum_reg;
        byte_slot_next    = byte_slot_reg;
        word_counter_next = word_counter_reg;
        words_wanted_next = words_wanted_reg;
        word_buffer_next  = word_buffer_reg;
        wait_counter_next = wait_counter_reg;
        job_push_next     = 1'b0;
        job_next          = '0;

        // write frame
        cmd1_w = {4'b0000, device_reg, write_op_reg};
        sum_w  = cmd1_w + {1'b0, item.reg_address} + item.write_data[7:0]
               + item.write_data[15:8] + item.write_data[23:16] + item.write_data[31:24];

        // read frames: word count clamped to 1..MAX_WORDS
        if (item.opcode == OP_READ)
            cnt = 5'd1;
        else if (item.word_count == 5'd0)
            cnt = 5'd1;
        else if (item.word_count > MAX_WORDS)
            cnt = MAX_WORDS;
        else
            cnt = item.word_count;
        cnt_m1 = cnt - 5'd1;
        cmd1_r = {cnt_m1[3:0], device_reg,
                  (item.opcode == OP_READ) ? read_op_reg : block_op_reg};
        cmd2_r = (item.opcode == OP_READ) ? {1'b0, item.reg_address} : 8'h00;

        // response byte assembly
        lane        = byte_slot_reg[1:0] - 2'd1;
        merged      = word_buffer_reg | ({24'b0, item.rx_byte} << {lane, 3'b000});
        rx_sum      = running_sum_reg + item.rx_byte;
        counter_inc = word_counter_reg + 5'd1;

        // timeout
        wait_inc = (wait_counter_reg == 8'hFF) ? wait_counter_reg : wait_counter_reg + 8'd1;
        case (phase_reg)
            PH_WRITE: limit = write_wait_reg;
            PH_READ:  limit = read_wait_reg;
            default:  limit = block_wait_reg;
        endcase

        if (take)
        begin
            case (item.opcode)
                OP_WRITE:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        job_push_next       = 1'b1;
                        job_next.is_frame   = 1'b1;
                        job_next.long_frame = 1'b1;
                        job_next.cmd1       = cmd1_w;
                        job_next.cmd2       = {1'b0, item.reg_address};
                        job_next.cksum      = finish_sum(sum_w);
                        job_next.data       = item.write_data;
                        phase_next          = PH_WRITE;
                        expected_sum_next   = finish_sum(sum_w);
                        running_sum_next    = 8'h00;
                        byte_slot_next      = SLOT_MARKER;
                        word_counter_next   = 5'd0;
                        words_wanted_next   = 5'd0;
                        word_buffer_next    = 32'h0;
                        wait_counter_next   = 8'h00;
                    end
                end
                OP_READ, OP_BLOCK:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        job_push_next     = 1'b1;
                        job_next.is_frame = 1'b1;
                        job_next.cmd1     = cmd1_r;
                        job_next.cmd2     = cmd2_r;
                        job_next.cksum    = finish_sum(cmd1_r + cmd2_r);
                        phase_next        = (item.opcode == OP_READ) ? PH_READ : PH_BLOCK;
                        running_sum_next  = cmd1_r + cmd2_r;
                        expected_sum_next = 8'h00;
                        byte_slot_next    = SLOT_MARKER;
                        word_counter_next = 5'd0;
                        words_wanted_next = cnt;
                        word_buffer_next  = 32'h0;
                        wait_counter_next = 8'h00;
                    end
                end
                OP_RX:
                begin
                    if (phase_reg == PH_WRITE)
                    begin
                        job_push_next = 1'b1;
                        job_next.kind = KIND_DONE;
                        job_next.ok   = (item.rx_byte == expected_sum_reg);
                        phase_next    = PH_IDLE;
                    end
                    else if (phase_reg != PH_IDLE)
                    begin
                        if (byte_slot_reg == SLOT_SUM)
                        begin
                            job_push_next     = 1'b1;
                            job_next.kind     = KIND_DONE;
                            job_next.ok       = (item.rx_byte == finish_sum(running_sum_reg));
                            expected_sum_next = finish_sum(running_sum_reg);
                            phase_next        = PH_IDLE;
                            byte_slot_next    = SLOT_MARKER;
                        end
                        else if (byte_slot_reg == SLOT_MARKER)
                        begin
                            // marker byte is neither checked nor summed
                            byte_slot_next   = SLOT_FIRST;
                            word_buffer_next = 32'h0;
                        end
                        else
                        begin
                            running_sum_next = rx_sum;
                            word_buffer_next = merged;
                            if (byte_slot_reg < SLOT_LAST)
                                byte_slot_next = byte_slot_reg + 3'd1;
                            else
                            begin
                                job_push_next     = 1'b1;
                                job_next.kind     = KIND_WORD;
                                job_next.data     = merged;
                                job_next.index    = word_counter_reg[3:0];
                                word_counter_next = counter_inc;
                                byte_slot_next    = (counter_inc >= words_wanted_reg)
                                                  ? SLOT_SUM : SLOT_MARKER;
                            end
                        end
                    end
                end
                OP_TICK:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        wait_counter_next = wait_inc;
                        if (wait_inc >= limit)
                        begin
                            job_push_next  = 1'b1;
                            job_next.kind  = KIND_DONE;
                            job_next.to    = 1'b1;
                            phase_next     = PH_IDLE;
                            byte_slot_next = SLOT_MARKER;
                        end
                    end
                end
                default:
                begin
                    job_push_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_reg       <= 2'd0;
            read_op_reg      <= 2'd1;
            write_op_reg     <= 2'd2;
            block_op_reg     <= 2'd3;
            write_wait_reg   <= 8'd50;
            read_wait_reg    <= 8'd100;
            block_wait_reg   <= 8'd200;
            phase_reg        <= PH_IDLE;
            expected_sum_reg <= 8'h00;
            running_sum_reg  <= 8'h00;
            byte_slot_reg    <= SLOT_MARKER;
            word_counter_reg <= 5'd0;
            words_wanted_reg <= 5'd0;
            word_buffer_reg  <= 32'h0;
            wait_counter_reg <= 8'h00;
            job_push         <= 1'b0;
            job              <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_DEVICE:     device_reg     <= cfg_data[1:0];
                    CFG_READ_OP:    read_op_reg    <= cfg_data[1:0];
                    CFG_WRITE_OP:   write_op_reg   <= cfg_data[1:0];
                    CFG_BLOCK_OP:   block_op_reg   <= cfg_data[1:0];
                    CFG_WRITE_WAIT: write_wait_reg <= cfg_data;
                    CFG_READ_WAIT:  read_wait_reg  <= cfg_data;
                    CFG_BLOCK_WAIT: block_wait_reg <= cfg_data;
                    default:        device_reg     <= device_reg;
                endcase
            end
            phase_reg        <= phase_next;
            expected_sum_reg <= expected_sum_next;
            running_sum_reg  <= running_sum_next;
            byte_slot_reg    <= byte_slot_next;
            word_counter_reg <= word_counter_next;
            words_wanted_reg <= words_wanted_next;
            word_buffer_reg  <= word_buffer_next;
            wait_counter_reg <= wait_counter_next;
            job_push         <= job_push_next;
            job              <= job_next;
        end
    end

endmodule

`default_nettype wire

[rtl/murl_queue.sv]
// short job queue between front and back end, flip-flop storage
// depends on murl_pkg for job_t and depth constants
`timescale 1ns / 1ps
`default_nettype none

module murl_queue (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr_en,
    input  wire murl_pkg::job_t wr_job,
    input  wire logic        rd_en,
    output murl_pkg::job_t   rd_job,
    output logic             not_empty,
    output logic             almost_full
);
    import murl_pkg::*;

    job_t                  slots [JOB_DEPTH];
    logic [JOB_PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [JOB_CNT_W-1:0]  count_reg;
    logic                  do_rd;

    assign do_rd     = rd_en && (count_reg != '0);
    assign not_empty = (count_reg != '0);
    assign rd_job    = slots[rd_ptr_reg];
    // front has one registered job in flight, so hold back one slot
    assign almost_full = (count_reg >= JOB_CNT_W'(JOB_DEPTH - 1));

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slots[wr_ptr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (wr_en && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (!wr_en && do_rd)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

[rtl/murl_back.sv]
// back end: expands jobs into result items through one output register
// depends on murl_pkg for job_t, result_t and frame constants
`timescale 1ns / 1ps
`default_nettype none

module murl_back (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         job_valid,
    input  wire murl_pkg::job_t job,
    output logic              job_done,
    input  wire logic         pop,
    output logic              empty,
    output murl_pkg::result_t out_item
);
    import murl_pkg::*;

    logic [2:0] byte_idx_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    logic       load, is_last;
    result_t    res;

    assign load     = !out_valid_reg || pop;
    assign job_done = load && job_valid && is_last;
    assign empty    = !out_valid_reg;
    assign out_item = out_reg;

    always_comb
    begin
        res = '0;
        if (job.is_frame)
        begin
            is_last         = job.long_frame ? (byte_idx_reg == 3'd7) : (byte_idx_reg == 3'd3);
            res.result_kind = KIND_TX;
            case (byte_idx_reg)
                3'd0:    res.tx_byte = HDR_BYTE;
                3'd1:    res.tx_byte = job.cmd1;
                3'd2:    res.tx_byte = job.cmd2;
                3'd3:    res.tx_byte = job.long_frame ? job.data[7:0] : job.cksum;
                3'd4:    res.tx_byte = job.data[15:8];
                3'd5:    res.tx_byte = job.data[23:16];
                3'd6:    res.tx_byte = job.data[31:24];
                default: res.tx_byte = job.cksum;
            endcase
        end
        else
        begin
            is_last         = 1'b1;
            res.result_kind = job.kind;
            res.read_word   = job.data;
            res.word_index  = job.index;
            res.checksum_ok = job.ok;
            res.timed_out   = job.to;
        end
        res.last = is_last;
    end

    always_ff @(posedge clk)
    begin
        if (load && job_valid)
            out_reg <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_idx_reg  <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= job_valid;
            if (job_valid)
                byte_idx_reg <= is_last ? 3'd0 : byte_idx_reg + 3'd1;
        end
    end

endmodule

`default_nettype wire

[rtl/meter_uart_register_link_top.sv]
// top level of the meter uart register link: front end, job queue, back end
// depends on murl_pkg, murl_front, murl_queue and murl_back
`timescale 1ns / 1ps
`default_nettype none

// host-side engine for a metering chip's uart register protocol. commands,
// received bytes and millisecond ticks come in through a queue-style push port;
// transmit bytes, received words and transaction-done results leave through a
// queue-style pop port. the front end takes each input request while full is
// low, updates the protocol state and posts at most one job into a four-entry
// job queue; the back end turns each job into results at one result per cycle
// while results are popped, through a registered output, so a write command
// yields eight results, a read or block read command four, and a received byte
// or tick at most one. full rises when the job queue is three deep, and stays
// low while the back end keeps up, so requests flow back to back. the user must
// write configuration registers via cfg_write/cfg_index/cfg_data only while the
// block is idle, which the block does not enforce; no clearing pass after reset.
module meter_uart_register_link_top (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // request side
    input  wire logic              push,
    output logic                   full,
    input  wire murl_pkg::in_item_t in_item,
    // result side
    output logic                   empty,
    input  wire logic              pop,
    output murl_pkg::result_t      out_item,
    // configuration writes
    input  wire logic              cfg_write,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [7:0]        cfg_data
);
    import murl_pkg::*;

    logic take;
    logic job_push;
    job_t front_job;
    job_t head_job;
    logic head_valid;
    logic head_done;

    // a request is taken whenever the queue has room for its job
    assign take = push && !full;

    murl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .item      (in_item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .job_push  (job_push),
        .job       (front_job)
    );

    // decouples classification from result expansion
    murl_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (job_push),
        .wr_job      (front_job),
        .rd_en       (head_done),
        .rd_job      (head_job),
        .not_empty   (head_valid),
        .almost_full (full)
    );

    murl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (head_valid),
        .job       (head_job),
        .job_done  (head_done),
        .pop       (pop),
        .empty     (empty),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire

[rtl/murl_checker.sv]
// port-level checks on the result side of the meter uart register link
// depends on murl_pkg; bound to meter_uart_register_link_top below
`timescale 1ns / 1ps
`default_nettype none

module murl_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              empty,
    input  wire logic              pop,
    input  wire murl_pkg::result_t out_item
);
    import murl_pkg::*;

    // a waiting result holds until popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_item)))
        else $error("result changed while waiting");

    // frame bytes leave without gaps or interleaving
    a_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && out_item.result_kind == KIND_TX && !out_item.last)
        |=> (!empty && out_item.result_kind == KIND_TX))
        else $error("frame broken up");

    // words and done results always close their request
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_item.result_kind != KIND_TX) |-> out_item.last)
        else $error("single result without last");

    // a timeout result is a done result without checksum_ok
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_item.timed_out) |->
        (out_item.result_kind == KIND_DONE && !out_item.checksum_ok))
        else $error("bad done result");

endmodule

bind meter_uart_register_link_top murl_checker u_murl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
);

`default_nettype wire

[dv/meter_uart_register_link_top_test.sv]
// self-checking testbench for meter_uart_register_link_top
// holds its own frame and response predictor in a scoreboard class; needs murl_pkg and the rtl
`timescale 1ns / 1ps

module meter_uart_register_link_top_test;

    import murl_pkg::*;

    // how a generated transaction ends
    localparam int ENDS_GOOD    = 0;
    localparam int ENDS_BAD     = 1;
    localparam int ENDS_TIMEOUT = 2;

    // cycles without any accepted request or result before the run is abandoned
    localparam int STUCK_LIMIT = 5000;
    // cycles the receiver holds off during the back-pressure burst
    localparam int HOLD_CYCLES = 400;

    // expected-result store plus a cycle-free copy of the protocol engine
    class link_scoreboard;
        typedef enum logic [1:0] {LINK_IDLE, LINK_WRITE, LINK_READ, LINK_BLOCK} link_state_t;

        // configuration copy
        logic [1:0] dev_addr, rd_op, wr_op, blk_op;
        logic [7:0] wr_limit, rd_limit, blk_limit;

        // protocol state copy
        link_state_t link_state;
        logic [7:0]  expected_sum, running_sum, wait_counter;
        logic [2:0]  byte_slot;
        logic [4:0]  word_counter, words_wanted;
        logic [31:0] word_buffer;

        result_t awaited_results[$];
        int      mismatch_count;

        function new();
            dev_addr = 2'd0;
            rd_op = 2'd1;
            wr_op = 2'd2;
            blk_op = 2'd3;
            wr_limit = 8'd50;
            rd_limit = 8'd100;
            blk_limit = 8'd200;
            link_state = LINK_IDLE;
            expected_sum = '0;
            running_sum = '0;
            wait_counter = '0;
            byte_slot = '0;
            word_counter = '0;
            words_wanted = '0;
            word_buffer = '0;
            mismatch_count = 0;
        endfunction

        function void set_register(input logic [2:0] idx, input logic [7:0] val);
            case (idx)
                CFG_DEVICE:     dev_addr = val[1:0];
                CFG_READ_OP:    rd_op = val[1:0];
                CFG_WRITE_OP:   wr_op = val[1:0];
                CFG_BLOCK_OP:   blk_op = val[1:0];
                CFG_WRITE_WAIT: wr_limit = val;
                CFG_READ_WAIT:  rd_limit = val;
                CFG_BLOCK_WAIT: blk_limit = val;
                default: ;
            endcase
        endfunction

        // bias plus inverted byte sum
        function logic [7:0] seal(input logic [7:0] s);
            logic [7:0] inv;
            inv = ~s;
            return SUM_BIAS + inv;
        endfunction

        function void add_result(input logic [1:0] k, input logic [7:0] tx,
                                 input logic [31:0] word, input logic [3:0] idx,
                                 input logic ok, input logic to, input logic fin);
            result_t res;
            res = '0;
            res.result_kind = k;
            res.tx_byte = tx;
            res.read_word = word;
            res.word_index = idx;
            res.checksum_ok = ok;
            res.timed_out = to;
            res.last = fin;
            awaited_results.push_back(res);
        endfunction

        function void add_tx(input logic [7:0] b, input logic fin);
            add_result(KIND_TX, b, 32'h0, 4'h0, 1'b0, 1'b0, fin);
        endfunction

        function void add_done(input logic ok, input logic to);
            add_result(KIND_DONE, 8'h00, 32'h0, 4'h0, ok, to, 1'b1);
        endfunction

        function void open_read(input logic [1:0] op, input logic [4:0] cnt,
                                input logic [6:0] addr, input link_state_t next_state);
            logic [4:0] cm1;
            logic [7:0] c1, c2;
            cm1 = cnt - 5'd1;
            c1 = {cm1[3:0], dev_addr, op};
            c2 = {1'b0, addr};
            add_tx(HDR_BYTE, 1'b0);
            add_tx(c1, 1'b0);
            add_tx(c2, 1'b0);
            add_tx(seal(c1 + c2), 1'b1);
            link_state = next_state;
            running_sum = c1 + c2;
            expected_sum = '0;
            byte_slot = '0;
            word_counter = '0;
            words_wanted = cnt;
            word_buffer = '0;
            wait_counter = '0;
        endfunction

        function void open_write(input in_item_t r);
            logic [7:0] frame [8];
            logic [7:0] s;
            frame[0] = HDR_BYTE;
            frame[1] = {4'h0, dev_addr, wr_op};
            frame[2] = {1'b0, r.reg_address};
            for (int i = 0; i < 4; i++)
                frame[3 + i] = r.write_data[8 * i +: 8];
            s = '0;
            for (int i = 1; i < 7; i++)
                s = s + frame[i];
            frame[7] = seal(s);
            for (int i = 0; i < 8; i++)
                add_tx(frame[i], i == 7);
            link_state = LINK_WRITE;
            expected_sum = frame[7];
            running_sum = '0;
            byte_slot = '0;
            word_counter = '0;
            words_wanted = '0;
            word_buffer = '0;
            wait_counter = '0;
        endfunction

        function void take_byte(input logic [7:0] rx);
            logic [7:0] want;
            int sh;
            if (link_state == LINK_IDLE)
                return;
            if (link_state == LINK_WRITE)
            begin
                add_done(rx == expected_sum, 1'b0);
                link_state = LINK_IDLE;
                return;
            end
            if (byte_slot == 3'd5)
            begin
                want = seal(running_sum);
                add_done(rx == want, 1'b0);
                expected_sum = want;
                link_state = LINK_IDLE;
                byte_slot = '0;
                return;
            end
            // marker is skipped and left out of the sum
            if (byte_slot == 3'd0)
            begin
                byte_slot = 3'd1;
                word_buffer = '0;
                return;
            end
            running_sum = running_sum + rx;
            sh = 8 * (int'(byte_slot) - 1);
            word_buffer[sh +: 8] = word_buffer[sh +: 8] | rx;
            if (byte_slot < 3'd4)
            begin
                byte_slot = byte_slot + 3'd1;
                return;
            end
            add_result(KIND_WORD, 8'h00, word_buffer, word_counter[3:0], 1'b0, 1'b0, 1'b1);
            word_counter = word_counter + 5'd1;
            byte_slot = (word_counter >= words_wanted) ? 3'd5 : 3'd0;
        endfunction

        function logic [7:0] limit_now();
            if (link_state == LINK_WRITE)
                return wr_limit;
            if (link_state == LINK_READ)
                return rd_limit;
            return blk_limit;
        endfunction

        function void take_tick();
            if (link_state == LINK_IDLE)
                return;
            if (wait_counter < 8'd255)
                wait_counter = wait_counter + 8'd1;
            if (wait_counter >= limit_now())
            begin
                add_done(1'b0, 1'b1);
                link_state = LINK_IDLE;
                byte_slot = '0;
            end
        endfunction

        // expected results of one accepted request
        function void note_request(input in_item_t r);
            logic [4:0] cnt;
            // commands are dropped while a transaction is open
            if (r.opcode <= OP_BLOCK && link_state != LINK_IDLE)
                return;
            case (r.opcode)
                OP_WRITE: open_write(r);
                OP_READ:  open_read(rd_op, 5'd1, r.reg_address, LINK_READ);
                OP_BLOCK:
                begin
                    cnt = r.word_count;
                    if (cnt == 5'd0)
                        cnt = 5'd1;
                    if (cnt > MAX_WORDS)
                        cnt = MAX_WORDS;
                    open_read(blk_op, cnt, 7'd0, LINK_BLOCK);
                end
                OP_RX:    take_byte(r.rx_byte);
                OP_TICK:  take_tick();
                default: ;
            endcase
        endfunction

        function void check_result(input result_t got);
            result_t want;
            if (awaited_results.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("unexpected result: kind %0d tx %02h word %08h",
                             got.result_kind, got.tx_byte, got.read_word,
                             " idx %0d ok %0b to %0b last %0b",
                             got.word_index, got.checksum_ok, got.timed_out, got.last);
                mismatch_count++;
                return;
            end
            want = awaited_results.pop_front();
            if (got.result_kind !== want.result_kind || got.tx_byte !== want.tx_byte ||
                got.read_word !== want.read_word || got.word_index !== want.word_index ||
                got.checksum_ok !== want.checksum_ok || got.timed_out !== want.timed_out ||
                got.last !== want.last)
            begin
                if (mismatch_count < 10)
                begin
                    $display("mismatch at %0t", $realtime);
                    $display("  expected: kind %0d tx %02h word %08h",
                             want.result_kind, want.tx_byte, want.read_word,
                             " idx %0d ok %0b to %0b last %0b",
                             want.word_index, want.checksum_ok, want.timed_out, want.last);
                    $display("  actual:   kind %0d tx %02h word %08h",
                             got.result_kind, got.tx_byte, got.read_word,
                             " idx %0d ok %0b to %0b last %0b",
                             got.word_index, got.checksum_ok, got.timed_out, got.last);
                end
                mismatch_count++;
            end
        endfunction

        // helpers that let the stimulus follow the protocol
        function int pending();
            return awaited_results.size();
        endfunction

        function bit busy();
            return link_state != LINK_IDLE;
        endfunction

        function bit at_checksum();
            return (link_state == LINK_READ || link_state == LINK_BLOCK) && byte_slot == 3'd5;
        endfunction

        function logic [7:0] good_reply();
            if (link_state == LINK_WRITE)
                return expected_sum;
            return seal(running_sum);
        endfunction

        function int ticks_left();
            return int'(limit_now()) - int'(wait_counter);
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    in_item_t   in_item;
    logic       empty;
    logic       pop;
    result_t    out_item;
    logic       cfg_write;
    logic [2:0] cfg_index;
    logic [7:0] cfg_data;

    link_scoreboard sb;
    bit sender_idle_on;
    bit receiver_idle_on;
    int hold_request;
    int sent_count;
    int stuck_cycles;

    meter_uart_register_link_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // every field random so that unused bits toggle too
    function automatic in_item_t random_item(input logic [2:0] op);
        in_item_t r;
        r.opcode = op;
        r.reg_address = 7'($urandom_range(0, 127));
        r.write_data = $urandom;
        r.word_count = 5'($urandom_range(0, 31));
        r.rx_byte = 8'($urandom_range(0, 255));
        return r;
    endfunction

    function automatic int pick_ending(input logic [7:0] lim);
        int r;
        r = $urandom_range(0, 9);
        // timeouts only where the limit keeps the tick count small
        if (r < 2 && lim <= 8'd24)
            return ENDS_TIMEOUT;
        if (r < 4)
            return ENDS_BAD;
        return ENDS_GOOD;
    endfunction

    // one request: optional gap, then hold push until accepted;
    // push is left high so a follow-on request can go back to back
    task automatic send_request(input in_item_t r);
        int gap;
        gap = sender_idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        in_item <= r;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_request(r);
        sent_count++;
    endtask

    task automatic send_rx(input logic [7:0] b);
        in_item_t r;
        r = random_item(OP_RX);
        r.rx_byte = b;
        send_request(r);
    endtask

    task automatic send_tick();
        send_request(random_item(OP_TICK));
    endtask

    // checksum byte for the open transaction, corrupted on request
    task automatic send_reply(input bit good);
        logic [7:0] b;
        b = sb.good_reply();
        if (!good)
            b = b ^ 8'($urandom_range(1, 255));
        send_rx(b);
    endtask

    // a tick that cannot end the wait
    task automatic maybe_tick();
        if ($urandom_range(0, 5) == 0 && sb.ticks_left() > 1)
            send_tick();
    endtask

    task automatic run_write(input int ending);
        send_request(random_item(OP_WRITE));
        if (ending == ENDS_TIMEOUT)
        begin
            while (sb.busy())
                send_tick();
        end
        else
        begin
            maybe_tick();
            send_reply(ending == ENDS_GOOD);
        end
    endtask

    task automatic run_read(input logic [2:0] op, input logic [4:0] wc, input int ending);
        in_item_t r;
        int n;
        r = random_item(op);
        r.word_count = wc;
        send_request(r);
        if (ending == ENDS_TIMEOUT)
        begin
            // part of the response, then ticks until the wait runs out
            n = $urandom_range(0, 8);
            repeat (n)
                if (sb.busy() && !sb.at_checksum())
                    send_rx(8'($urandom_range(0, 255)));
            while (sb.busy())
                send_tick();
        end
        else
        begin
            while (sb.busy())
            begin
                maybe_tick();
                // a stray command mid-response must be dropped
                if ($urandom_range(0, 19) == 0)
                    send_request(random_item(3'($urandom_range(OP_WRITE, OP_BLOCK))));
                if (sb.at_checksum())
                    send_reply(ending == ENDS_GOOD);
                else
                    send_rx(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // received bytes, ticks and spare opcodes while nothing is open
    task automatic run_noise();
        int n;
        int r;
        n = $urandom_range(1, 3);
        repeat (n)
        begin
            r = $urandom_range(0, 2);
            if (r == 0)
                send_request(random_item(OP_RX));
            else if (r == 1)
                send_tick();
            else
                send_request(random_item(OP_TICK + 3'($urandom_range(1, 3))));
        end
    endtask

    task automatic run_mix(input int target);
        int r;
        logic [4:0] wc;
        while (sent_count < target)
        begin
            if ($urandom_range(0, 7) == 0)
                sender_idle_on = !sender_idle_on;
            if ($urandom_range(0, 7) == 0)
                receiver_idle_on = !receiver_idle_on;
            r = $urandom_range(0, 99);
            if (r < 30)
                run_write(pick_ending(sb.wr_limit));
            else if (r < 58)
                run_read(OP_READ, 5'd1, pick_ending(sb.rd_limit));
            else if (r < 85)
            begin
                // mostly short blocks, sometimes any count the field allows
                wc = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                                 : 5'($urandom_range(1, 3));
                run_read(OP_BLOCK, wc, pick_ending(sb.blk_limit));
            end
            else
                run_noise();
        end
    endtask

    // stop offering and wait until every awaited result has come out
    task automatic settle();
        push <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic put_register(input logic [2:0] idx, input logic [7:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        sb.set_register(idx, val);
    endtask

    task automatic setup_phase(input logic [1:0] dev, input logic [1:0] rop,
                               input logic [1:0] wop, input logic [1:0] bop,
                               input logic [7:0] ww, input logic [7:0] rw,
                               input logic [7:0] bw);
        settle();
        put_register(CFG_DEVICE, {6'd0, dev});
        put_register(CFG_READ_OP, {6'd0, rop});
        put_register(CFG_WRITE_OP, {6'd0, wop});
        put_register(CFG_BLOCK_OP, {6'd0, bop});
        put_register(CFG_WRITE_WAIT, ww);
        put_register(CFG_READ_WAIT, rw);
        put_register(CFG_BLOCK_WAIT, bw);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // short directed pass under reset configuration
    task automatic run_directed();
        in_item_t r;
        // ignored while idle: tick, received byte, spare opcodes
        send_tick();
        send_rx(8'hFF);
        send_request(random_item(OP_TICK + 3'd1));
        send_request(random_item(OP_TICK + 3'd3));
        // write with all-ones fields, echo matches
        r = random_item(OP_WRITE);
        r.reg_address = 7'h7F;
        r.write_data = 32'hFFFF_FFFF;
        send_request(r);
        send_reply(1'b1);
        // write with all-zero fields, echo wrong
        r = random_item(OP_WRITE);
        r.reg_address = 7'h00;
        r.write_data = 32'h0000_0000;
        send_request(r);
        send_reply(1'b0);
        // single read, command while busy in the middle, good checksum
        r = random_item(OP_READ);
        r.reg_address = 7'h7F;
        send_request(r);
        send_rx(8'h00);
        send_rx(8'hFF);
        send_rx(8'h00);
        send_request(random_item(OP_WRITE));
        send_rx(8'hFF);
        send_rx(8'h00);
        send_reply(1'b1);
        // block read with a zero count acts as one word, bad checksum
        r = random_item(OP_BLOCK);
        r.word_count = 5'd0;
        send_request(r);
        repeat (5) send_rx(8'($urandom_range(0, 255)));
        send_reply(1'b0);
    endtask

    // fill the job queue while the receiver is held off
    task automatic pressure_burst();
        bit saved;
        saved = sender_idle_on;
        sender_idle_on = 1'b0;
        hold_request = HOLD_CYCLES;
        repeat (5) run_write(ENDS_GOOD);
        sender_idle_on = saved;
    endtask

    // result side: check on every accepted pop, then choose next pop level
    initial
    begin
        int pop_gap;
        pop_gap = 0;
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                sb.check_result(out_item);
            if (hold_request > 0)
            begin
                pop_gap = hold_request;
                hold_request = 0;
            end
            if (pop_gap > 0)
            begin
                pop <= 1'b0;
                pop_gap--;
            end
            else
            begin
                pop <= 1'b1;
                if (receiver_idle_on && $urandom_range(0, 3) == 0)
                    pop_gap = pick_gap();
            end
        end
    end

    // watchdog: cycles with neither a request nor a result accepted
    initial
    begin
        stuck_cycles = 0;
        while (stuck_cycles < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("** meter_uart_register_link_top: FAILED **");
        $finish;
    end

    // main sequence
    initial
    begin
        sb = new();
        push = 1'b0;
        in_item = '0;
        pop = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_DEVICE;
        cfg_data = 8'h00;
        rst_n = 1'b0;
        sender_idle_on = 1'b1;
        receiver_idle_on = 1'b1;
        hold_request = 0;
        sent_count = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();

        // low extremes: tiny wait limits, timeouts come quickly
        setup_phase(2'd3, 2'd0, 2'd3, 2'd1, 8'd1, 8'd2, 8'd3);
        run_mix(120);

        // high extremes: back pressure, then one oversized block read
        setup_phase(2'd1, 2'd2, 2'd1, 2'd0, 8'd255, 8'd255, 8'd255);
        pressure_burst();
        settle();
        run_read(OP_BLOCK, 5'd31, ENDS_GOOD);
        run_mix(220);

        // zero write limit times out on the first tick
        setup_phase(2'd2, 2'd3, 2'd0, 2'd2, 8'd0, 8'd7, 8'd12);
        run_mix(290);

        setup_phase(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                    2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                    8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                    8'($urandom_range(1, 255)));
        run_mix(360);

        push <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (sb.mismatch_count == 0 && sb.pending() == 0)
            $display("** meter_uart_register_link_top: PASSED **");
        else
            $display("** meter_uart_register_link_top: FAILED **");
        $finish;
    end

endmodule

[meter_uart_register_link_top.f]
rtl/murl_pkg.sv
rtl/murl_front.sv
rtl/murl_queue.sv
rtl/murl_back.sv
rtl/meter_uart_register_link_top.sv
rtl/murl_checker.sv
dv/meter_uart_register_link_top_test.sv
